### design/cdte_pkg.sv
// shared types, constants and small tables for the civil date to epoch converter
package cdte_pkg;

  localparam logic [11:0] YEAR_MIN     = 12'd1970;
  localparam logic [11:0] YEAR_MAX     = 12'd2199;
  localparam logic [11:0] YEAR_NO_LEAP = 12'd2100;  // only century year in range that is not leap
  localparam logic [11:0] ERA5_START   = 12'd2000;
  localparam logic [11:0] ERA4_START   = 12'd1600;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  localparam logic [4:0]  HOUR_MAX     = 5'd23;
  localparam logic [5:0]  MINSEC_MAX   = 6'd59;

  localparam int DAYS_W  = 17;
  localparam int TOD_W   = 17;
  localparam int EPOCH_W = 34;
  localparam int QUOT_W  = 14;

  // era * 146097 - 719468, for era 5 and era 4, modulo 2^19
  localparam logic [18:0] DAY_OFS_ERA5 = 19'd11017;
  localparam logic [18:0] DAY_OFS_ERA4 = 19'd389208;  // -135080

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [16:0] WDAY_SHIFT    = 17'd4;       // 1970-01-01 was a thursday
  localparam logic [17:0] RECIP_7       = 18'd149797;  // ceil(2^20 / 7)
  localparam int          RECIP_SH      = 20;

  typedef struct packed {
    logic        ok;
    logic        era5;
    logic [8:0]  yoe;
    logic [8:0]  doy;
    logic [TOD_W-1:0] tod;
  } cdte_s1_t;

  typedef struct packed {
    logic              ok;
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } cdte_s2_t;

  typedef struct packed {
    logic               ok;
    logic [EPOCH_W-1:0] secs_day;
    logic [TOD_W-1:0]   tod;
    logic [DAYS_W-1:0]  wx;
    logic [QUOT_W-1:0]  quot;
  } cdte_s3_t;

  // days before the shifted month, march-based: (153*mp + 2) / 5
  function automatic logic [8:0] cum_days(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // yoe / 100 for yoe below 400
  function automatic logic [1:0] div100(input logic [8:0] yoe);
    logic [1:0] r;
    if (yoe >= 9'd300) begin
      r = 2'd3;
    end else if (yoe >= 9'd200) begin
      r = 2'd2;
    end else if (yoe >= 9'd100) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

endpackage

### design/cdte_check.sv
// stage 1: field checks, era split, day of year and time of day
module cdte_check (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [11:0]          year,
  input  logic [3:0]           month,
  input  logic [4:0]           day,
  input  logic [4:0]           hour,
  input  logic [5:0]           minute,
  input  logic [5:0]           second,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cdte_pkg::cdte_s1_t   out_data
);

  logic               valid;
  cdte_pkg::cdte_s1_t data;
  cdte_pkg::cdte_s1_t data_next;

  logic        leap;
  logic [4:0]  mlen;
  logic [11:0] yadj;
  logic [11:0] yoe_full;
  logic [3:0]  mp;

  always_comb begin
    leap = (year[1:0] == 2'b00) && (year != cdte_pkg::YEAR_NO_LEAP);
    mlen = cdte_pkg::month_len(month, leap);
    // jan and feb count as the end of the previous year
    yadj = (month <= cdte_pkg::MONTH_FEB) ? (year - 12'd1) : year;
    data_next.era5 = (yadj >= cdte_pkg::ERA5_START);
    yoe_full = data_next.era5 ? (yadj - cdte_pkg::ERA5_START) : (yadj - cdte_pkg::ERA4_START);
    data_next.yoe = yoe_full[8:0];
    mp = (month > cdte_pkg::MONTH_FEB) ? (month - 4'd3) : (month + 4'd9);
    data_next.doy = cdte_pkg::cum_days(mp) + 9'(day) - 9'd1;
    data_next.tod = 17'(hour) * cdte_pkg::SECS_PER_HOUR
                  + 17'(minute) * cdte_pkg::SECS_PER_MIN + 17'(second);
    data_next.ok = (year >= cdte_pkg::YEAR_MIN) && (year <= cdte_pkg::YEAR_MAX)
                && (month != 4'd0) && (month <= cdte_pkg::MONTH_DEC)
                && (day != 5'd0) && (day <= mlen)
                && (hour <= cdte_pkg::HOUR_MAX)
                && (minute <= cdte_pkg::MINSEC_MAX) && (second <= cdte_pkg::MINSEC_MAX);
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### design/cdte_days.sv
// stage 2: day of era and days since the epoch
module cdte_days (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdte_pkg::cdte_s1_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cdte_pkg::cdte_s2_t out_data
);

  logic               valid;
  cdte_pkg::cdte_s2_t data;
  cdte_pkg::cdte_s2_t data_next;

  logic [17:0] doe;
  logic [18:0] days_full;

  always_comb begin
    doe = 18'(in_data.yoe) * 18'd365 + 18'(in_data.yoe[8:2])
        - 18'(cdte_pkg::div100(in_data.yoe)) + 18'(in_data.doy);
    days_full = 19'(doe) + (in_data.era5 ? cdte_pkg::DAY_OFS_ERA5 : cdte_pkg::DAY_OFS_ERA4);
    data_next.ok   = in_data.ok;
    data_next.days = days_full[cdte_pkg::DAYS_W-1:0];
    data_next.tod  = in_data.tod;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### design/cdte_mul.sv
// stage 3: seconds of whole days and reciprocal multiply for the weekday
module cdte_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdte_pkg::cdte_s2_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cdte_pkg::cdte_s3_t out_data
);

  logic               valid;
  cdte_pkg::cdte_s3_t data;
  cdte_pkg::cdte_s3_t data_next;

  logic [34:0] qprod;

  always_comb begin
    data_next.ok       = in_data.ok;
    data_next.tod      = in_data.tod;
    data_next.secs_day = 34'(in_data.days) * 34'(cdte_pkg::SECS_PER_DAY);
    data_next.wx       = in_data.days + cdte_pkg::WDAY_SHIFT;
    // exact floor(wx / 7) for wx well below 2^18
    qprod              = 35'(data_next.wx) * 35'(cdte_pkg::RECIP_7);
    data_next.quot     = qprod[cdte_pkg::RECIP_SH +: cdte_pkg::QUOT_W];
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### design/cdte_fin.sv
// stage 4: final add, weekday remainder and invalid masking into the output register
module cdte_fin (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdte_pkg::cdte_s3_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               date_ok,
  output logic signed [33:0] epoch_seconds,
  output logic signed [3:0]  weekday
);

  logic              valid;
  logic              ok;
  logic [33:0]       epoch;
  logic [3:0]        wday;
  logic [33:0]       epoch_next;
  logic [3:0]        wday_next;
  logic [16:0]       rem;

  always_comb begin
    rem = in_data.wx - 17'(in_data.quot) * 17'd7;
    if (in_data.ok) begin
      epoch_next = in_data.secs_day + 34'(in_data.tod);
      wday_next  = {1'b0, rem[2:0]};
    end else begin
      epoch_next = '1;
      wday_next  = '1;
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ok    <= in_data.ok;
      epoch <= epoch_next;
      wday  <= wday_next;
    end
  end

  assign out_valid     = valid;
  assign date_ok       = ok;
  assign epoch_seconds = signed'(epoch);
  assign weekday       = signed'(wday);

endmodule

### design/civil_date_to_epoch_seconds.sv
// top level of the civil date to epoch seconds converter
//
//  channel  handshake              payload
//  req      req_valid / req_ready  year, month, day, hour, minute, second
//  rsp      rsp_valid / rsp_ready  date_ok, epoch_seconds, weekday
//
// four register stages, one beat per cycle sustained while rsp is not
// stalled; the depth is set by the chain of checks, day count, constant
// multiplies and final add
// every stage holds its own valid bit and loads when empty or when the
// stage after it moves, so bubbles close up while rsp is stalled
// rst is synchronous and clears only the valid bits; no other state is kept
module civil_date_to_epoch_seconds (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [11:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic               date_ok,
  output logic signed [33:0] epoch_seconds,
  output logic signed [3:0]  weekday
);

  // stage handoff
  logic               s1_valid;
  logic               s1_ready;
  cdte_pkg::cdte_s1_t s1_data;
  logic               s2_valid;
  logic               s2_ready;
  cdte_pkg::cdte_s2_t s2_data;
  logic               s3_valid;
  logic               s3_ready;
  cdte_pkg::cdte_s3_t s3_data;

  // checks, era split (era 4 or 5 only), day of year, time of day
  cdte_check u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .year      (year),
    .month     (month),
    .day       (day),
    .hour      (hour),
    .minute    (minute),
    .second    (second),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // day of era, then rebased to days since 1970-01-01
  cdte_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // days times 86400, and the quotient by 7 for the weekday
  cdte_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  // add time of day, take the remainder, force all ones on a bad date
  cdte_fin u_fin (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s3_valid),
    .in_ready      (s3_ready),
    .in_data       (s3_data),
    .out_valid     (rsp_valid),
    .out_ready     (rsp_ready),
    .date_ok       (date_ok),
    .epoch_seconds (epoch_seconds),
    .weekday       (weekday)
  );

endmodule

### bench/date_epoch_checker.sv
// checker that predicts and compares every converted date beat
`timescale 1ns / 100ps
module date_epoch_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  logic [11:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  logic               date_ok,
  input  logic signed [33:0] epoch_seconds,
  input  logic signed [3:0]  weekday,
  output int                 fail_cnt,
  output int                 open_cnt,
  output int                 rsp_beats,
  output int                 ok_beats
);

  localparam longint DAYS_PER_ERA = 146097;
  localparam longint EPOCH_SHIFT  = 719468;
  localparam longint SECS_PER_DAY = 86400;

  typedef struct packed {
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [4:0]  hr;
    logic [5:0]  mn;
    logic [5:0]  sc;
    logic        ok;
    logic [33:0] secs;
    logic [3:0]  wday;
  } epoch_result_t;

  epoch_result_t due_results[$];
  int mism = 0;
  int rsp_seen = 0;
  int ok_seen = 0;

  function automatic bit leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // era-based day count from the civil date, then seconds and weekday
  function automatic epoch_result_t civil_to_epoch(input logic [11:0] y_in,
                                                   input logic [3:0] m, input logic [4:0] d,
                                                   input logic [4:0] h, input logic [5:0] mi,
                                                   input logic [5:0] s);
    epoch_result_t r;
    longint y, era, yoe, mp, doy, doe, days, secs, wd;
    int mlen;
    r = '0;
    r.yr = y_in; r.mo = m; r.dy = d; r.hr = h; r.mn = mi; r.sc = s;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: mlen = 30;
      cdte_pkg::MONTH_FEB:     mlen = leap_year(longint'(y_in)) ? 29 : 28;
      default:                 mlen = 31;
    endcase
    r.ok = (y_in >= cdte_pkg::YEAR_MIN) && (y_in <= cdte_pkg::YEAR_MAX) &&
           (m >= 4'd1) && (m <= cdte_pkg::MONTH_DEC) &&
           (d >= 5'd1) && (d <= mlen) &&
           (h <= cdte_pkg::HOUR_MAX) && (mi <= cdte_pkg::MINSEC_MAX) &&
           (s <= cdte_pkg::MINSEC_MAX);
    if (!r.ok) begin
      r.secs = '1;
      r.wday = '1;
      return r;
    end
    y = (m <= cdte_pkg::MONTH_FEB) ? longint'(y_in) - 1 : longint'(y_in);
    era = y / 400;
    yoe = y - era * 400;
    mp = (m > cdte_pkg::MONTH_FEB) ? longint'(m) - 3 : longint'(m) + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * DAYS_PER_ERA + doe - EPOCH_SHIFT;
    secs = days * SECS_PER_DAY + h * 3600 + mi * 60 + s;
    wd = (days + 4) % 7;
    r.secs = secs[33:0];
    r.wday = wd[3:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mism++;
    $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin : watch
    epoch_result_t want;
    string stamp;
    if (rst) begin
      due_results.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: ok=%0b epoch=%0d wday=%0d",
                                    date_ok, epoch_seconds, weekday));
        end else begin
          want = due_results.pop_front();
          stamp = $sformatf("%0d-%0d-%0d %0d:%0d:%0d", want.yr, want.mo, want.dy,
                            want.hr, want.mn, want.sc);
          if (date_ok !== want.ok) begin
            report_mismatch($sformatf("%s date_ok got %b want %b", stamp, date_ok, want.ok));
          end
          if (epoch_seconds !== want.secs) begin
            report_mismatch($sformatf("%s epoch_seconds got %h want %h", stamp,
                                      epoch_seconds, want.secs));
          end
          if (weekday !== want.wday) begin
            report_mismatch($sformatf("%s weekday got %h want %h", stamp, weekday, want.wday));
          end
          if (want.ok) begin
            ok_seen++;
          end
        end
      end
      if (req_valid && req_ready) begin
        due_results.push_back(civil_to_epoch(year, month, day, hour, minute, second));
      end
    end
    fail_cnt  <= mism;
    open_cnt  <= due_results.size();
    rsp_beats <= rsp_seen;
    ok_beats  <= ok_seen;
  end

endmodule

### bench/tb_top.sv
// top of the bench: clock, reset, date stimulus and final verdict
`timescale 1ns / 100ps
module tb_top;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_TAIL    = 300;   // closing stretch with no idling at all

  logic               clk = 1'b0;
  logic               rst;
  logic               req_valid;
  logic               req_ready;
  logic [11:0]        year;
  logic [3:0]         month;
  logic [4:0]         day;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic               date_ok;
  logic signed [33:0] epoch_seconds;
  logic signed [3:0]  weekday;

  int fail_cnt;
  int open_cnt;
  int rsp_beats;
  int ok_beats;

  int idle_pct = 0;     // chance in percent that a beat starts an idle burst
  int stall_left = 0;   // remaining cycles of the current rsp stall burst
  int dates_sent = 0;

  civil_date_to_epoch_seconds u_dut (.*);

  // watches both channels, predicts every result and counts mismatches
  date_epoch_checker u_checker (.*);

  always #5 clk = ~clk;

  // rsp side back-pressure: bursts of stalled cycles at the current idle rate
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rst && ($urandom_range(0, 99) < idle_pct)) begin
      rsp_ready  <= 1'b0;
      stall_left <= int'($urandom_range(0, 4));
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  function automatic int month_length(input logic [11:0] y, input logic [3:0] m);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      cdte_pkg::MONTH_FEB:     return leap ? 29 : 28;
      default:                 return 31;
    endcase
  endfunction

  // one req beat; may open with an idle burst, then holds valid until accepted
  task automatic send_date(input logic [11:0] y, input logic [3:0] m, input logic [4:0] d,
                           input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req_valid <= 1'b1;
    year      <= y;
    month     <= m;
    day       <= d;
    hour      <= h;
    minute    <= mi;
    second    <= s;
    @(posedge clk);
    while (!req_ready) begin
      @(posedge clk);
    end
    dates_sent++;
  endtask

  // mostly well-formed dates, mixed at random with dates broken in one field and raw noise
  task automatic send_random_date();
    logic [11:0] y;
    logic [3:0]  m;
    logic [4:0]  d, h;
    logic [5:0]  mi, s;
    int pick, mlen;
    y    = 12'($urandom_range(cdte_pkg::YEAR_MIN, cdte_pkg::YEAR_MAX));
    m    = 4'($urandom_range(1, cdte_pkg::MONTH_DEC));
    mlen = month_length(y, m);
    d    = 5'($urandom_range(1, mlen));
    h    = 5'($urandom_range(0, cdte_pkg::HOUR_MAX));
    mi   = 6'($urandom_range(0, cdte_pkg::MINSEC_MAX));
    s    = 6'($urandom_range(0, cdte_pkg::MINSEC_MAX));
    pick = int'($urandom_range(0, 99));
    if (pick >= 85) begin
      // every bit of every field free
      y  = 12'($urandom);
      m  = 4'($urandom);
      d  = 5'($urandom);
      h  = 5'($urandom);
      mi = 6'($urandom);
      s  = 6'($urandom);
    end else if (pick >= 65) begin
      case ($urandom_range(0, 6))
        0:       y  = $urandom_range(0, 1) ? 12'($urandom_range(0, cdte_pkg::YEAR_MIN - 1))
                                           : 12'($urandom_range(cdte_pkg::YEAR_MAX + 1, 4095));
        1:       m  = $urandom_range(0, 1) ? 4'd0
                                           : 4'($urandom_range(cdte_pkg::MONTH_DEC + 1, 15));
        2:       d  = (mlen == 31 || $urandom_range(0, 1)) ? 5'd0
                                                            : 5'($urandom_range(mlen + 1, 31));
        3:       h  = 5'($urandom_range(cdte_pkg::HOUR_MAX + 1, 31));
        4:       mi = 6'($urandom_range(cdte_pkg::MINSEC_MAX + 1, 63));
        5:       s  = 6'($urandom_range(cdte_pkg::MINSEC_MAX + 1, 63));
        default: begin
          // leap day in a random year, valid only when the year is leap
          m = cdte_pkg::MONTH_FEB;
          d = 5'd29;
        end
      endcase
    end
    send_date(y, m, d, h, mi, s);
  endtask

  initial begin : stimulus
    int n;
    rst       = 1'b1;
    req_valid = 1'b0;
    year      = '0;
    month     = '0;
    day       = '0;
    hour      = '0;
    minute    = '0;
    second    = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed dates: range edges, leap rules and every out-of-range field
    idle_pct = 20;
    send_date(12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0);   // the epoch itself
    send_date(12'd2199, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);  // last valid second
    send_date(12'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);  // year just below range
    send_date(12'd2200, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0);   // year just above range
    send_date(12'd0,    4'd0,  5'd0,  5'd0,  6'd0,  6'd0);   // all zeros
    send_date(12'hfff,  4'hf,  5'h1f, 5'h1f, 6'h3f, 6'h3f);  // all ones
    send_date(12'd2000, 4'd2,  5'd29, 5'd12, 6'd0,  6'd0);   // leap by the 400 rule
    send_date(12'd2100, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0);   // century year, not leap
    send_date(12'd2100, 4'd2,  5'd28, 5'd23, 6'd59, 6'd59);
    send_date(12'd2024, 4'd2,  5'd29, 5'd6,  6'd30, 6'd15);  // ordinary leap day
    send_date(12'd2023, 4'd2,  5'd29, 5'd6,  6'd30, 6'd15);  // leap day in a common year
    send_date(12'd2000, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0);   // first day after an era leap day
    send_date(12'd2038, 4'd1,  5'd19, 5'd3,  6'd14, 6'd8);   // just past the 32-bit limit
    send_date(12'd2021, 4'd4,  5'd31, 5'd0,  6'd0,  6'd0);   // day 31 in a 30-day month
    send_date(12'd2021, 4'd4,  5'd30, 5'd0,  6'd0,  6'd0);
    send_date(12'd2021, 4'd1,  5'd31, 5'd0,  6'd0,  6'd0);
    send_date(12'd2021, 4'd13, 5'd1,  5'd0,  6'd0,  6'd0);   // month past december
    send_date(12'd2021, 4'd0,  5'd10, 5'd0,  6'd0,  6'd0);   // month zero
    send_date(12'd2021, 4'd6,  5'd0,  5'd0,  6'd0,  6'd0);   // day zero
    send_date(12'd2021, 4'd6,  5'd15, 5'd24, 6'd0,  6'd0);   // hour 24
    send_date(12'd2021, 4'd6,  5'd15, 5'd31, 6'd0,  6'd0);
    send_date(12'd2021, 4'd6,  5'd15, 5'd23, 6'd60, 6'd0);   // minute 60
    send_date(12'd2021, 4'd6,  5'd15, 5'd0,  6'd63, 6'd0);
    send_date(12'd2021, 4'd6,  5'd15, 5'd23, 6'd59, 6'd60);  // second 60
    send_date(12'd2021, 4'd6,  5'd15, 5'd0,  6'd0,  6'd63);

    // random dates in chunks, each chunk with its own idle rate, calm at the end
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_TAIL) begin
        idle_pct = 0;
      end else if (n % 200 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      send_random_date();
    end
    @(negedge clk);
    req_valid <= 1'b0;

    // drain the pipeline, then give a stray beat a chance to show up
    while (open_cnt != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("run covered %0d date beats and %0d result beats: %0d valid, %0d rejected",
             dates_sent, rsp_beats, ok_beats, rsp_beats - ok_beats);
    $display("idle and stall bursts on both channels, none in the closing stretch");
    if (fail_cnt == 0) begin
      $display("PASS civil_date_to_epoch_seconds");
    end else begin
      $display("FAIL civil_date_to_epoch_seconds");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("timeout with %0d results still expected", open_cnt);
    $display("FAIL civil_date_to_epoch_seconds");
    $finish;
  end

endmodule

### civil_date_to_epoch_seconds.f
design/cdte_pkg.sv
design/cdte_check.sv
design/cdte_days.sv
design/cdte_mul.sv
design/cdte_fin.sv
design/civil_date_to_epoch_seconds.sv
bench/date_epoch_checker.sv
bench/tb_top.sv
